// ===== hdl/sfsc_pkg.sv =====
// Shared types and constants for the SYN flood source counter.
package sfsc_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATE_W  = 8;
  localparam int unsigned CFG_W    = 16;

  localparam logic [STATE_W-1:0] HALF_OPEN_CODE = 8'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [CFG_W-1:0]   THRESHOLD_RST  = 16'd30;
  localparam logic [CFG_W-1:0]   BUDGET_RST     = 16'd1023;

  typedef enum logic [2:0] {
    ST_NOT_SYN     = 3'd0,
    ST_COUNTED     = 3'd1,
    ST_OVER_BUDGET = 3'd2,
    ST_TABLE_FULL  = 3'd3,
    ST_PASS_START  = 3'd4
  } status_t;

  typedef enum logic {
    CFG_SYN_THRESHOLD = 1'b0,
    CFG_RECORD_BUDGET = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic               blk;
    logic [COUNT_W-1:0] count;
  } match_res_t;

endpackage

// ===== hdl/sfsc_if.sv =====
// Valid/ready channel interfaces for connection records and results.
interface sfsc_in_if import sfsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [ADDR_W-1:0]  remote_ip;
  logic [STATE_W-1:0] conn_state;

  modport source (output valid, action, remote_ip, conn_state, input ready);
  modport sink   (input valid, action, remote_ip, conn_state, output ready);
endinterface

interface sfsc_out_if import sfsc_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic               block_request;
  logic [ADDR_W-1:0]  source_ip;
  logic [COUNT_W-1:0] sightings;

  modport source (output valid, status, block_request, source_ip, sightings,
                  input ready);
  modport sink   (input valid, status, block_request, source_ip, sightings,
                  output ready);
endinterface

// ===== hdl/sfsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfsc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sfsc_match_unit.sv =====
// Shared address comparator with saturating count update and threshold check.
module sfsc_match_unit import sfsc_pkg::*; (
  input  logic [ADDR_W-1:0] key,
  input  entry_t            entry,
  input  logic [CFG_W-1:0]  threshold,
  output match_res_t        res
);

  logic [COUNT_W-1:0] inc;
  logic [COUNT_W:0]   seen;

  always_comb begin
    inc       = entry.count + COUNT_W'(1);
    seen      = {1'b0, inc} + (COUNT_W+1)'(1);
    res.hit   = (entry.addr == key);
    if (entry.count != COUNT_MAX) begin
      res.count = inc;
      res.blk   = (seen == {1'b0, threshold});
    end else begin
      // hold a saturated count; it can no longer reach any threshold
      res.count = entry.count;
      res.blk   = 1'b0;
    end
  end

endmodule

// ===== hdl/syn_flood_source_counter_unit.sv =====
// Top level: per-source half-open connection counter with sequential table search.
//
// Usage: connection records enter on in_ch (valid/ready) and each one yields
// exactly one result transaction on out_ch. action = 1 starts a new pass:
// the source table and the budget counter are cleared and status 4 returns.
// Records are counted against record_budget; half-open records are looked up
// in a table of TABLE_ENTRIES sources, updated or inserted, and a block
// request is raised on the threshold-th sighting of a source.
// Pass-start, over-budget and non-SYN records return in the cycle after
// acceptance. A half-open record scans the filled part of the table through
// one RAM read port and one comparator, one entry per cycle: a hit ends the
// scan when its entry is compared, and a new source or a full table ends it
// once every filled entry has been compared.
// Throughput: one record at a time; in_ch.ready is low during the scan.
// The table is filled in order, so a fill count replaces per-entry valid bits
// and no clearing pass is needed after reset or at a pass start.
// Reset (synchronous rst_n low) empties the table, clears the budget counter
// and restores syn_threshold = 30 and record_budget = 1023.
// A stalled receiver holds the result in the output register; the next record
// is accepted in the cycle the result is taken.
// cfg writes are expected only while the block is idle.
module syn_flood_source_counter_unit import sfsc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  sfsc_in_if.sink           in_ch,
  sfsc_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(TABLE_ENTRIES);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CFG_W-1:0]   used_r, used_nxt;
  logic [CFG_W-1:0]   thr_r, thr_nxt;
  logic [CFG_W-1:0]   budget_r, budget_nxt;
  logic [ADDR_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_blk_r, out_blk_nxt;
  logic [ADDR_W-1:0]  out_ip_r, out_ip_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic               in_ready;
  logic               in_fire;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  match_res_t         mres;

  sfsc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  sfsc_match_unit u_match (
    .key       (key_r),
    .entry     (ram_rdata),
    .threshold (thr_r),
    .res       (mres)
  );

  // Accept only when idle and the result slot is free or emptying now.
  assign in_ready     = (state_r == IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.block_request = out_blk_r;
  assign out_ch.source_ip     = out_ip_r;
  assign out_ch.sightings     = out_cnt_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    used_nxt       = used_r;
    thr_nxt        = thr_r;
    budget_nxt     = budget_r;
    key_nxt        = key_r;
    rd_idx_nxt     = rd_idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;
    out_ip_nxt     = out_ip_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_wdata      = '{addr: key_r, count: mres.count};

    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SYN_THRESHOLD: thr_nxt    = cfg_data;
        CFG_RECORD_BUDGET: budget_nxt = cfg_data;
      endcase
    end

    // drop the result once the receiver takes it
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      IDLE: begin
        if (in_fire) begin
          out_blk_nxt = 1'b0;
          out_ip_nxt  = '0;
          out_cnt_nxt = '0;
          if (in_ch.action) begin
            fill_nxt       = '0;
            used_nxt       = '0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_PASS_START;
          end else if (used_r >= budget_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OVER_BUDGET;
          end else begin
            used_nxt = used_r + CFG_W'(1);
            if (in_ch.conn_state != HALF_OPEN_CODE) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOT_SYN;
            end else begin
              key_nxt     = in_ch.remote_ip;
              rd_idx_nxt  = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = SCAN;
            end
          end
        end
      end
      SCAN: begin
        // advance the read pointer over the filled entries
        chk_vld_nxt = (rd_idx_r < fill_r);
        chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        if (rd_idx_r < fill_r) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (chk_vld_r && mres.hit) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_idx_r;
          chk_vld_nxt    = 1'b0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_COUNTED;
          out_blk_nxt    = mres.blk;
          out_ip_nxt     = key_r;
          out_cnt_nxt    = mres.count;
          state_nxt      = IDLE;
        end else if (!chk_vld_r && (rd_idx_r == fill_r)) begin
          // no match: insert at the first free entry, or report a full table
          out_valid_nxt = 1'b1;
          out_blk_nxt   = 1'b0;
          out_cnt_nxt   = '0;
          if (fill_r != FULL_FILL) begin
            ram_we         = 1'b1;
            ram_waddr      = fill_r[IDX_W-1:0];
            ram_wdata      = '{addr: key_r, count: '0};
            fill_nxt       = fill_r + CNT_W'(1);
            out_status_nxt = ST_COUNTED;
            out_ip_nxt     = key_r;
          end else begin
            out_status_nxt = ST_TABLE_FULL;
            out_ip_nxt     = '0;
          end
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      fill_r      <= '0;
      used_r      <= '0;
      thr_r       <= THRESHOLD_RST;
      budget_r    <= BUDGET_RST;
      rd_idx_r    <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
      thr_r       <= thr_nxt;
      budget_r    <= budget_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    chk_idx_r    <= chk_idx_nxt;
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_ip_r     <= out_ip_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_FILL)
    else $error("table fill count exceeds table size");

  a_scan_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SCAN |-> !out_valid_r)
    else $error("result slot busy during table scan");

  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == SCAN)
    else $error("table written outside scan");

  a_check_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> {1'b0, chk_idx_r} < {1'b0, fill_r})
    else $error("compared entry beyond fill");

  a_pass_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.action |=> fill_r == '0 && used_r == '0)
    else $error("pass start did not clear table");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the SYN flood source counter unit.
import sfsc_pkg::*;

typedef struct {
  status_t            status;
  logic               block;
  logic [ADDR_W-1:0]  ip;
  logic [COUNT_W-1:0] count;
} source_report_t;

// Per-source half-open tally: mirrors the source table, the budget counter and
// the two registers, and holds the reports still owed by the block.
class source_tally #(int SLOTS = 64);
  logic [ADDR_W-1:0]  slot_addr [SLOTS];
  logic [COUNT_W-1:0] slot_count[SLOTS];
  bit                 slot_used [SLOTS];
  logic [15:0]        records_used;
  logic [CFG_W-1:0]   threshold;
  logic [CFG_W-1:0]   budget;
  source_report_t     due_reports[$];
  int                 mismatches;

  function new();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    records_used = '0;
    threshold    = THRESHOLD_RST;
    budget       = BUDGET_RST;
    mismatches   = 0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    if (idx == CFG_SYN_THRESHOLD) threshold = val;
    else budget = val;
  endfunction

  function void owe(status_t st, logic blk, logic [ADDR_W-1:0] ip, logic [COUNT_W-1:0] cnt);
    source_report_t r;
    r.status = st;
    r.block  = blk;
    r.ip     = ip;
    r.count  = cnt;
    due_reports.push_back(r);
  endfunction

  function void note_record(logic act, logic [ADDR_W-1:0] ip, logic [STATE_W-1:0] st);
    int          free_slot;
    int unsigned c;
    logic        blk;
    free_slot = -1;
    if (act) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      records_used = '0;
      owe(ST_PASS_START, 1'b0, '0, '0);
      return;
    end
    if (records_used >= budget) begin
      owe(ST_OVER_BUDGET, 1'b0, '0, '0);
      return;
    end
    records_used = records_used + 16'd1;
    if (st != HALF_OPEN_CODE) begin
      owe(ST_NOT_SYN, 1'b0, '0, '0);
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        if (slot_addr[i] == ip) begin
          c   = slot_count[i];
          blk = 1'b0;
          // saturated counts stop matching any threshold
          if (c < COUNT_MAX) begin
            c++;
            blk = (c + 1 == int'(threshold));
          end
          slot_count[i] = c[COUNT_W-1:0];
          owe(ST_COUNTED, blk, ip, c[COUNT_W-1:0]);
          return;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot < 0) begin
      owe(ST_TABLE_FULL, 1'b0, '0, '0);
      return;
    end
    // a new source starts at zero sightings
    slot_used[free_slot]  = 1'b1;
    slot_addr[free_slot]  = ip;
    slot_count[free_slot] = '0;
    owe(ST_COUNTED, 1'b0, ip, '0);
  endfunction

  function void check_report(source_report_t got);
    source_report_t want;
    if (due_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result status=%0d block=%0b ip=%h sightings=%0d",
                 got.status, got.block, got.ip, got.count);
      return;
    end
    want = due_reports.pop_front();
    if (got.status !== want.status || got.block !== want.block ||
        got.ip !== want.ip || got.count !== want.count) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: expected status=%0d block=%0b ip=%h sightings=%0d",
                 want.status, want.block, want.ip, want.count);
        $display("       actual   status=%0d block=%0b ip=%h sightings=%0d",
                 got.status, got.block, got.ip, got.count);
      end
    end
  endfunction

  function int pending();
    return due_reports.size();
  endfunction
endclass

module tb_top;
  localparam int TABLE_ENTRIES = 64;
  localparam int NUM_PHASES    = 12;
  // generous bound: every record scanning a full table under heavy stalls
  localparam longint RUN_LIMIT = 64'd24_000_000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int sender_idle_pct;
  int recv_stall_pct;

  // per-phase register settings, source pool size, length and pass-start rate
  int phase_thr  [NUM_PHASES] = '{2, 30, 5, 1, 65535, 0, 3, 12, 2, 8, 4, 16};
  int phase_bud  [NUM_PHASES] = '{1023, 65535, 40, 0, 200, 1023, 65535, 100, 1, 500,
                                  65535, 300};
  int phase_pool [NUM_PHASES] = '{6, 3, 4, 5, 90, 8, 70, 5, 2, 64, 100, 10};
  int phase_items[NUM_PHASES] = '{140, 160, 140, 30, 140, 140, 150, 140, 140, 150, 160, 140};
  int phase_pass [NUM_PHASES] = '{2, 1, 4, 2, 2, 2, 1, 3, 20, 1, 1, 3};

  source_tally #(TABLE_ENTRIES) tally;

  sfsc_in_if  in_ch();
  sfsc_out_if out_ch();

  syn_flood_source_counter_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: drop ready at random according to the current stall rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch both channels at each edge: check the result first, then predict the
  // transaction just accepted, so results always pop older expectations.
  always @(posedge clk) begin : watch
    source_report_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.status = out_ch.status;
        seen.block  = out_ch.block_request;
        seen.ip     = out_ch.source_ip;
        seen.count  = out_ch.sightings;
        tally.check_report(seen);
      end
      if (in_ch.valid && in_ch.ready)
        tally.note_record(in_ch.action, in_ch.remote_ip, in_ch.conn_state);
    end
  end

  // Hold one transaction on the input until accepted, then maybe idle.
  task automatic send_record(input logic act, input logic [ADDR_W-1:0] ip,
                             input logic [STATE_W-1:0] st);
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.remote_ip  <= ip;
    in_ch.conn_state <= st;
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Stop sending and advance until every expected result has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tally.pending() != 0);
  endtask

  // Write both registers on back-to-back edges; the block must be idle.
  task automatic program_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] bud);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYN_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= CFG_RECORD_BUDGET;
    cfg_data  <= bud;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tally.set_reg(CFG_SYN_THRESHOLD, thr);
    tally.set_reg(CFG_RECORD_BUDGET, bud);
  endtask

  // Drain, let a full table scan's worth of cycles pass, then reprogram.
  task automatic settle_and_program(input logic [CFG_W-1:0] thr,
                                    input logic [CFG_W-1:0] bud);
    wait_for_results();
    repeat (TABLE_ENTRIES + 3) @(posedge clk);
    program_regs(thr, bud);
  endtask

  initial begin
    logic [ADDR_W-1:0]  ip_pool[128];
    logic [ADDR_W-1:0]  ip;
    logic [STATE_W-1:0] st;
    tally = new();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_SYN_THRESHOLD;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= 1'b0;
    in_ch.remote_ip  <= '0;
    in_ch.conn_state <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, address extremes, non-SYN states, pass start
    // with junk fields.
    send_record(1'b0, 32'h0000_0000, HALF_OPEN_CODE);
    send_record(1'b0, 32'h0000_0000, HALF_OPEN_CODE);
    send_record(1'b0, 32'hFFFF_FFFF, HALF_OPEN_CODE);
    send_record(1'b0, 32'hFFFF_FFFF, 8'd0);
    send_record(1'b0, 32'h1234_5678, 8'd255);
    send_record(1'b0, 32'h0000_0000, 8'd2);
    send_record(1'b0, 32'h0000_0000, 8'd4);
    send_record(1'b1, 32'hFFFF_FFFF, HALF_OPEN_CODE);

    // Threshold 2 fires on the second sighting; a budget of 4 runs out.
    settle_and_program(16'd2, 16'd4);
    send_record(1'b0, 32'hA5A5_0001, HALF_OPEN_CODE);
    send_record(1'b0, 32'hA5A5_0001, HALF_OPEN_CODE);
    send_record(1'b0, 32'hA5A5_0001, HALF_OPEN_CODE);
    send_record(1'b0, 32'h5A5A_0002, 8'd7);
    send_record(1'b0, 32'hA5A5_0001, HALF_OPEN_CODE);
    send_record(1'b1, 32'h0000_0000, 8'd0);

    // Threshold 1 never fires; a zero budget ignores every record.
    settle_and_program(16'd1, 16'd0);
    send_record(1'b0, 32'hA5A5_0001, HALF_OPEN_CODE);
    send_record(1'b1, 32'h8000_0000, 8'd128);
    send_record(1'b0, 32'h0000_0001, HALF_OPEN_CODE);

    // Threshold 3 with the largest budget: request on the third sighting.
    settle_and_program(16'd3, 16'd65535);
    send_record(1'b0, 32'hC0A8_0001, HALF_OPEN_CODE);
    send_record(1'b0, 32'hC0A8_0001, HALF_OPEN_CODE);
    send_record(1'b0, 32'hC0A8_0001, HALF_OPEN_CODE);
    send_record(1'b1, 32'h0000_0000, 8'd0);

    // Random phases: mostly half-open records from a small pool of sources so
    // counts climb to the threshold, with stray addresses, other states and
    // pass starts mixed in. Large pools overflow the table.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_and_program(phase_thr[p][CFG_W-1:0], phase_bud[p][CFG_W-1:0]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int k = 0; k < 128; k++) ip_pool[k] = $urandom;
      for (int n = 0; n < phase_items[p]; n++) begin
        if ($urandom_range(99) < phase_pass[p]) begin
          send_record(1'b1, $urandom, 8'($urandom));
        end else begin
          ip = ($urandom_range(99) < 5) ? $urandom
                                        : ip_pool[$urandom_range(phase_pool[p] - 1)];
          st = ($urandom_range(99) < 85) ? HALF_OPEN_CODE : 8'($urandom);
          send_record(1'b0, ip, st);
        end
        // Occasionally hold the sender until the block has emptied out.
        if ($urandom_range(199) == 0) wait_for_results();
      end
    end

    sender_idle_pct = 0;
    wait_for_results();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (tally.mismatches == 0 && tally.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== syn_flood_source_counter_unit.f =====
hdl/sfsc_pkg.sv
hdl/sfsc_if.sv
hdl/sfsc_ram.sv
hdl/sfsc_match_unit.sv
hdl/syn_flood_source_counter_unit.sv
verif/tb_top.sv
